// ===== rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants for the line-of-sight horizon scan
// Command/status bundles, register indexes, CORDIC and curvature constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

	typedef enum logic [1:0] {
		REG_RADAR_ALT  = 2'd0,
		REG_RANGE_STEP = 2'd1,
		REG_MAX_RANGE  = 2'd2,
		REG_BEAM_ELEV  = 2'd3
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic square;
		logic load_div;
		logic init_beam;
		logic init_hor;
		logic init_atan;
		logic cordic_step;
		logic cap_beam;
		logic cap_hor;
		logic mul_hor;
		logic mul_beam;
		logic finish;
	} lsh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cordic_last;
		logic div_done;
		logic out_free;
	} lsh_status_t;

	localparam int CW       = 50;   // CORDIC x/y width
	localparam int ZW       = 28;   // CORDIC angle width
	localparam int DIV_BITS = 44;   // curvature dividend width

	localparam logic [19:0] DROP_DIVISOR = 20'd796375;
	localparam logic [43:0] DROP_BIAS    = 44'd398187;
	// floor(2^51 / divisor); dividend[43:12] * this >> 39 is at most one low
	localparam logic [31:0] DROP_RECIP   = 32'((64'd1 << 51) / 64'(DROP_DIVISOR));

	localparam logic signed [25:0] HALF_PI_Q24  = 26'sd26353589;
	localparam logic signed [26:0] HORIZON_NONE = -27'sd67108864;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 50'sd652032874;

	localparam logic [23:0] ATAN_TAB [32] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214,  24'd524117,  24'd262123,  24'd131069,
		24'd65536,    24'd32768,   24'd16384,   24'd8192,
		24'd4096,     24'd2048,    24'd1024,    24'd512,
		24'd256,      24'd128,     24'd64,      24'd32,
		24'd16,       24'd8,       24'd4,       24'd2,
		24'd1,        24'd0,       24'd0,       24'd0,
		24'd0,        24'd0,       24'd0,       24'd0
	};

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] res;
		if (v > 33'sd2147483647)
			res = 32'sh7fffffff;
		else if (v < -33'sd2147483648)
			res = 32'sh80000000;
		else
			res = v[31:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsh_ctrl: sequencer for one terrain sample
// Steps the datapath through square, divide, sines, atan2 and output.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_ctrl import lsh_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  lsh_status_t status,
	output lsh_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQUARE, ST_LOAD, ST_SINB, ST_LOADH, ST_SINH,
		ST_WAITDIV, ST_LOADA, ST_ATAN, ST_MULH, ST_MULB, ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_SQUARE;
				ST_SQUARE:  state_q <= ST_LOAD;
				ST_LOAD:    state_q <= ST_SINB;
				ST_SINB:    if (status.cordic_last) state_q <= ST_LOADH;
				ST_LOADH:   state_q <= ST_SINH;
				ST_SINH:    if (status.cordic_last) state_q <= ST_WAITDIV;
				ST_WAITDIV: if (status.div_done) state_q <= ST_LOADA;
				ST_LOADA:   state_q <= ST_ATAN;
				ST_ATAN:    if (status.cordic_last) state_q <= ST_MULH;
				ST_MULH:    state_q <= ST_MULB;
				ST_MULB:    state_q <= ST_FIN;
				ST_FIN:     if (status.out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		in_ready        = (state_q == ST_IDLE);
		cmd.accept      = (state_q == ST_IDLE) && in_valid;
		cmd.square      = (state_q == ST_SQUARE);
		cmd.load_div    = (state_q == ST_LOAD);
		cmd.init_beam   = (state_q == ST_LOAD);
		cmd.cordic_step = (state_q == ST_SINB) || (state_q == ST_SINH) ||
		                  (state_q == ST_ATAN);
		cmd.cap_beam    = (state_q == ST_LOADH);
		cmd.init_hor    = (state_q == ST_LOADH);
		cmd.cap_hor     = (state_q == ST_WAITDIV);
		cmd.init_atan   = (state_q == ST_LOADA);
		cmd.mul_hor     = (state_q == ST_MULH);
		cmd.mul_beam    = (state_q == ST_MULB);
		cmd.finish      = (state_q == ST_FIN) && status.out_free;
	end

endmodule

`default_nettype wire

// ===== rtl/lsh_datapath.sv =====
// ----------------------------------------------------------------------------
// lsh_datapath: registers, curvature divider, shared CORDIC and multiplier
// Config registers, radial state and the output register live here too.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_datapath import lsh_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_wr_en,
	input  wire  [1:0]   cfg_index,
	input  wire  [25:0]  cfg_data,
	input  wire  [23:0]  in_data,
	input  lsh_cmd_t     cmd,
	output lsh_status_t  status,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [111:0] out_data,
	output logic         out_last
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	// divider stages, counted down from DIV_MUL; 3..1 are correction steps
	localparam logic [2:0] DIV_MUL = 3'd6;
	localparam logic [2:0] DIV_QUO = 3'd5;
	localparam logic [2:0] DIV_REM = 3'd4;

	// configuration
	logic signed [23:0] alt_q;
	logic        [15:0] step_q;
	logic        [19:0] max_q;
	logic signed [25:0] beam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q  <= '0;
			step_q <= 16'd500;
			max_q  <= 20'd100000;
			beam_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADAR_ALT:  alt_q  <= cfg_data[23:0];
				REG_RANGE_STEP: step_q <= cfg_data[15:0];
				REG_MAX_RANGE:  max_q  <= cfg_data[19:0];
				REG_BEAM_ELEV:  beam_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sample capture and range advance
	logic signed [23:0] ter_q;
	logic        [19:0] r_q;
	logic               last_q;
	logic        [19:0] cur_q;
	logic        [20:0] r_sum;
	logic        [19:0] r_next;

	assign r_sum  = {1'b0, cur_q} + {5'b0, step_q};
	assign r_next = (r_sum > {1'b0, max_q}) ? max_q : r_sum[19:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ter_q  <= in_data;
			r_q    <= r_next;
			last_q <= (r_next >= max_q);
		end
	end

	// curvature drop: (12 r^2 + bias) / divisor by reciprocal multiply;
	// the estimate is never high and at most one low, so a compare and
	// subtract finishes it
	logic [39:0]         rr_q;
	logic [DIV_BITS-1:0] num_q;
	logic [63:0]         recip_q;
	logic [24:0]         quo_q;
	logic [44:0]         quo_prod;
	logic [21:0]         rem_q;
	logic [2:0]          div_cnt_q;
	logic [24:0]         drop;

	assign quo_prod = quo_q * DROP_DIVISOR;
	assign drop     = quo_q;

	always_ff @(posedge clk) begin
		if (cmd.square)
			rr_q <= r_q * r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load_div) begin
			div_cnt_q <= DIV_MUL;
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div)
			num_q <= {1'b0, rr_q, 3'b0} + {2'b0, rr_q, 2'b0} + DROP_BIAS;
		case (div_cnt_q)
			DIV_MUL: recip_q <= num_q[DIV_BITS-1:DIV_BITS-32] * DROP_RECIP;
			DIV_QUO: quo_q   <= recip_q[63:39];
			DIV_REM: rem_q   <= 22'(num_q - quo_prod[DIV_BITS-1:0]);
			3'd3, 3'd2, 3'd1: begin
				if (rem_q >= {2'b0, DROP_DIVISOR}) begin
					quo_q <= quo_q + 25'd1;
					rem_q <= rem_q - {2'b0, DROP_DIVISOR};
				end
			end
			default: ;
		endcase
	end

	// shared CORDIC: rotation for sines, vectoring for atan2
	logic signed [CW-1:0]  x_q, y_q, xs, ys;
	logic signed [ZW-1:0]  z_q, tab;
	logic [CNT_W-1:0]      cnt_q;
	logic                  vec_q;
	logic                  rot_up;
	logic signed [25:0]    bclamp;
	logic signed [26:0]    dy;
	logic signed [CW-1:0]  sin_full;
	logic signed [25:0]    bsin_q, hsin_q;
	logic signed [26:0]    horizon_q;

	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign tab    = ZW'({4'b0, ATAN_TAB[5'(cnt_q)]});
	assign rot_up = vec_q ? !(y_q > 0) : (z_q >= 0);
	assign bclamp = (beam_q > HALF_PI_Q24) ? HALF_PI_Q24 :
	                (beam_q < -HALF_PI_Q24) ? -HALF_PI_Q24 : beam_q;
	assign dy     = 27'(ter_q) - 27'(alt_q) + $signed({2'b0, drop});
	assign sin_full = (y_q + 50'sd32) >>> 6;

	always_ff @(posedge clk) begin
		if (cmd.init_beam || cmd.init_hor) begin
			x_q   <= CORDIC_GAIN_Q30;
			y_q   <= '0;
			z_q   <= cmd.init_beam ? ZW'(bclamp) : ZW'(horizon_q);
			vec_q <= 1'b0;
		end else if (cmd.init_atan) begin
			x_q   <= $signed({6'b0, r_q, 24'b0});
			y_q   <= CW'(dy) <<< 16;
			z_q   <= '0;
			vec_q <= 1'b1;
		end else if (cmd.cordic_step) begin
			if (rot_up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end
		end
		if (cmd.cap_beam) bsin_q <= sin_full[25:0];
		if (cmd.cap_hor)  hsin_q <= sin_full[25:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.init_beam || cmd.init_hor || cmd.init_atan)
			cnt_q <= '0;
		else if (cmd.cordic_step)
			cnt_q <= cnt_q + 1'b1;
	end

	// heights: h + round(r*sin) - drop, saturated
	logic signed [26:0] el_q;
	logic signed [46:0] prod_q;
	logic signed [32:0] ray;
	logic signed [31:0] ray_sat;
	logic signed [31:0] ter32;
	logic signed [31:0] minv_q;
	logic               lit_q;
	logic               lit;

	assign ray     = 33'(alt_q) + 33'((prod_q + 47'sd32768) >>> 16) -
	                 $signed({8'b0, drop});
	assign ray_sat = sat32(ray);
	assign ter32   = 32'(ter_q);
	assign lit     = el_q > horizon_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_hor) begin
			if (r_q == '0)
				el_q <= (dy > 0) ? 27'(HALF_PI_Q24) :
				        (dy < 0) ? -27'(HALF_PI_Q24) : '0;
			else
				el_q <= z_q[26:0];
			prod_q <= $signed({1'b0, r_q}) * hsin_q;
		end
		if (cmd.mul_beam) begin
			lit_q  <= lit;
			minv_q <= lit ? ter32 : ((ray_sat > ter32) ? ray_sat : ter32);
			prod_q <= $signed({1'b0, r_q}) * bsin_q;
		end
	end

	// radial state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			horizon_q <= HORIZON_NONE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid <= 1'b1;
				if (last_q) begin
					cur_q     <= '0;
					horizon_q <= HORIZON_NONE;
				end else begin
					cur_q <= r_q;
					if (lit_q)
						horizon_q <= el_q;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data <= {4'b0, ray_sat, minv_q, ter_q, r_q};
			out_last <= last_q;
		end
	end

	assign status.cordic_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign status.div_done    = (div_cnt_q == '0);
	assign status.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/line_of_sight_horizon_scan.sv =====
// ----------------------------------------------------------------------------
// line_of_sight_horizon_scan: radial viewshed with 4/3-Earth curvature
// Horizon tracking over terrain samples, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one terrain height (Q8 m, signed) per range step along a
//    radial. Each request yields exactly one m_axis request: range, echoed
//    terrain, lowest visible altitude and beam-top altitude; tlast marks the
//    sample at max_range, after which the radial restarts (range 0, horizon
//    cleared).
//  - Configuration: cfg_wr_en/cfg_index/cfg_data, write-only, one register
//    per cycle. Write only while no sample is in flight; new values apply to
//    the next sample.
//  - From accept to tvalid a sample steps through square, divider load, beam
//    sine, horizon sine, divider wait, atan2, horizon and beam multiplies and
//    finish; a new sample is taken only after the last one finishes. The
//    shared CORDIC unit runs three passes per sample (beam sine, horizon sine,
//    atan2) and sets the rate. The curvature divider (reciprocal multiply,
//    compare and subtract) overlaps the beam sine pass.
//  - One sample in flight; s_axis_tready is high only while idle.
//  - The result sits in an output register: the next sample is accepted
//    while it waits, and that sample's result holds until m_axis_tready.
//  - Reset (arst_n low) restores register defaults and starts a new radial.
// ----------------------------------------------------------------------------
`default_nettype none

module line_of_sight_horizon_scan import lsh_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire          clk,
	input  wire          arst_n,
	// config: index 0 radar_altitude, 1 range_step, 2 max_range,
	// 3 beam_max_elevation
	input  wire          cfg_wr_en,
	input  wire  [1:0]   cfg_index,
	input  wire  [25:0]  cfg_data,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [23:0]  s_axis_tdata,   // [23:0] terrain_height
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// [19:0] range_m, [43:20] terrain_out, [75:44] min_visible,
	// [107:76] max_coverage, [111:108] zero
	output logic [111:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	lsh_cmd_t    cmd;
	lsh_status_t status;

	lsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lsh_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// one sample at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request accepted while busy");

	// a result appears only from the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.finish))
		else $error("result valid without finish");

	// curvature drop must be complete before use
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_atan || cmd.finish |-> status.div_done)
		else $error("curvature divider still running");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for line_of_sight_horizon_scan
// A directed table of terrain samples and register writes, then about 1400
// random samples over four idling phases. Every result is checked field by
// field against a bit-exact predictor: curvature drop, CORDIC atan2 and sine,
// horizon tracking and restart at the end of the radial.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import lsh_pkg::*;

	localparam int STEPS      = 24;
	localparam int LIMIT      = 3000000;  // cycles, several times the slowest run
	localparam int SETTLE     = 100;      // wait after the last result drains
	localparam int PHASE_SMPS = 350;
	localparam int CFG_EVERY  = 40;       // samples between config changes

	typedef struct packed {
		logic        last;
		logic [31:0] max_cov;
		logic [31:0] min_vis;
		logic [23:0] terrain;
		logic [19:0] range_m;
	} scan_result_t;

	typedef struct {
		bit           is_cfg;
		cfg_reg_t     idx;
		logic [25:0]  val;
		bit           typed;       // expected result given in the row
		scan_result_t res;
	} plan_row_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [25:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;
	logic         m_axis_tlast;

	line_of_sight_horizon_scan #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// predictor copy of registers and scan state
	longint antenna_alt = 0;
	longint step_m      = 500;
	longint max_rng     = 100000;
	longint beam_elev   = 0;
	longint beam_sin    = 0;
	longint horizon     = longint'(HORIZON_NONE);
	longint cur_rng     = 0;

	scan_result_t pending_results[$];
	int  mismatches = 0;
	int  cycles = 0;
	int  idle_pct = 0;      // sender gap chance, percent
	int  stall_pct = 0;     // receiver stall chance, percent
	int  hold_left = 0;     // long receiver hold-off, cycles
	plan_row_t plan[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// vectoring CORDIC, elevation angle in Q24
	function automatic longint elev_angle(longint y, longint x);
		longint z, dx, dy;
		int k;
		z = 0;
		if (x == 0)
			return (y > 0) ? longint'(HALF_PI_Q24) :
			       ((y < 0) ? -longint'(HALF_PI_Q24) : 0);
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < STEPS; i++) begin
			k = i & 31;
			dx = y >>> k;
			dy = x >>> k;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
			end
		end
		return z;
	endfunction

	// rotation CORDIC sine, Q24 in and out
	function automatic longint sine_q24(longint z);
		longint x, y, dx, dy;
		int k;
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			k = i & 31;
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
			end
		end
		return (y + 32) >>> 6;
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic scan_result_t scan_sample(logic [23:0] t);
		scan_result_t res;
		longint ter, r, drop, el, mv, mc, hv;
		ter = longint'($signed(t));
		r = cur_rng + step_m;
		if (r > max_rng)
			r = max_rng;
		drop = (12 * r * r + 398187) / 796375;
		el = elev_angle(ter - antenna_alt + drop, r * 256);
		if (el > horizon) begin
			horizon = el;
			mv = ter;
		end else begin
			// shadowed: the horizon ray or the terrain, whichever is higher
			hv = antenna_alt + ((r * sine_q24(horizon) + 32768) >>> 16) - drop;
			mv = (hv > ter) ? hv : ter;
		end
		mc = antenna_alt + ((r * beam_sin + 32768) >>> 16) - drop;
		res.range_m = r[19:0];
		res.terrain = t;
		res.min_vis = clip32(mv);
		res.max_cov = clip32(mc);
		res.last    = (r >= max_rng);
		if (res.last) begin
			cur_rng = 0;
			horizon = longint'(HORIZON_NONE);
		end else begin
			cur_rng = r;
		end
		return res;
	endfunction

	// writes one register and mirrors it; block must be idle
	task automatic write_reg(cfg_reg_t idx, logic [25:0] val);
		longint a;
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_RADAR_ALT:  antenna_alt = longint'($signed(val[23:0]));
			REG_RANGE_STEP: step_m = longint'(val[15:0]);
			REG_MAX_RANGE:  max_rng = longint'(val[19:0]);
			REG_BEAM_ELEV: begin
				beam_elev = longint'($signed(val));
				a = beam_elev;
				if (a > longint'(HALF_PI_Q24))
					a = longint'(HALF_PI_Q24);
				if (a < -longint'(HALF_PI_Q24))
					a = -longint'(HALF_PI_Q24);
				beam_sin = sine_q24(a);
			end
		endcase
	endtask

	// offers one sample, returns after it is accepted; tvalid stays high
	task automatic send_sample(logic [23:0] t, bit typed, scan_result_t typed_res);
		scan_result_t res;
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= t;
		do @(posedge clk); while (!s_axis_tready);
		res = scan_sample(t);
		pending_results = {pending_results, (typed ? typed_res : res)};
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: check accepted results, random stalls, optional long hold
	always @(posedge clk) begin
		scan_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.range_m = m_axis_tdata[19:0];
			got.terrain = m_axis_tdata[43:20];
			got.min_vis = m_axis_tdata[75:44];
			got.max_cov = m_axis_tdata[107:76];
			got.last    = m_axis_tlast;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.range_m !== want.range_m || got.terrain !== want.terrain ||
				    got.min_vis !== want.min_vis || got.max_cov !== want.max_cov ||
				    got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: range %0d/%0d terrain %h/%h ",
							"min_vis %h/%h max_cov %h/%h last %b/%b"},
							want.range_m, got.range_m, want.terrain, got.terrain,
							want.min_vis, got.min_vis, want.max_cov, got.max_cov,
							want.last, got.last);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [25:0] val);
		plan_row_t p;
		p.is_cfg = 1'b1;
		p.idx    = idx;
		p.val    = val;
		p.typed  = 1'b0;
		p.res    = '0;
		return p;
	endfunction

	function automatic plan_row_t smp_row(logic [23:0] t, bit typed, scan_result_t res);
		plan_row_t p;
		p.is_cfg = 1'b0;
		p.idx    = REG_RADAR_ALT;
		p.val    = {2'b00, t};
		p.typed  = typed;
		p.res    = res;
		return p;
	endfunction

	function automatic void add_row(plan_row_t p);
		plan = {plan, p};
	endfunction

	function automatic logic [23:0] rand_terrain();
		case ($urandom_range(3))
			0:       return 24'($urandom());
			1:       return 24'(antenna_alt[23:0] + $urandom_range(20000) - 10000);
			default: return 24'($urandom_range(512000));  // 0..2000 m
		endcase
	endfunction

	task automatic rand_config();
		int st, mx;
		if ($urandom_range(1))
			write_reg(REG_RADAR_ALT, 26'($urandom() & 32'hffffff));
		else
			write_reg(REG_RADAR_ALT, 26'($urandom_range(256000)));
		st = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 3000);
		write_reg(REG_RANGE_STEP, 26'(st));
		// keep radials short so the end of radial comes often
		mx = ($urandom_range(7) == 0) ? $urandom_range(1, 1048575) : st * $urandom_range(1, 30);
		if (mx > 1048575)
			mx = 1048575;
		write_reg(REG_MAX_RANGE, 26'(mx));
		write_reg(REG_BEAM_ELEV, 26'($urandom()));
	endtask

	initial begin
		scan_result_t none, r0, r1;
		none = '0;
		// first sample after reset: 500 m, drop 4, lit, beam sine still 0
		r0 = '{last: 1'b0, max_cov: -32'sd4, min_vis: 32'd0, terrain: 24'd0,
			range_m: 20'd500};
		// zero range: angle +pi/2, always lit and always last
		r1 = '{last: 1'b1, max_cov: 32'd0, min_vis: 32'd256, terrain: 24'd256,
			range_m: 20'd0};

		add_row(smp_row(24'd0, 1, r0));
		add_row(smp_row(24'h7fffff, 0, none));
		add_row(smp_row(24'h800000, 0, none));
		add_row(smp_row(24'd0, 0, none));
		add_row(cfg_row(REG_RADAR_ALT, 26'h0800000));
		add_row(smp_row(24'd0, 0, none));
		add_row(smp_row(24'h800000, 0, none));
		add_row(cfg_row(REG_RADAR_ALT, 26'h07fffff));
		add_row(cfg_row(REG_BEAM_ELEV, 26'(26353589)));
		add_row(smp_row(24'h7fffff, 0, none));
		add_row(smp_row(24'd0, 0, none));
		add_row(cfg_row(REG_BEAM_ELEV, 26'(-26353589)));
		add_row(smp_row(24'd0, 0, none));
		// elevation beyond pi/2 either way, clamped before the sine
		add_row(cfg_row(REG_BEAM_ELEV, 26'h1ffffff));
		add_row(smp_row(24'd100, 0, none));
		add_row(cfg_row(REG_BEAM_ELEV, 26'h2000000));
		add_row(smp_row(24'd100, 0, none));
		// zero step: range repeats, equal angle is shadowed
		add_row(cfg_row(REG_RANGE_STEP, 26'd0));
		add_row(smp_row(24'd5000, 0, none));
		add_row(smp_row(24'd5000, 0, none));
		add_row(cfg_row(REG_RANGE_STEP, 26'd65535));
		add_row(cfg_row(REG_MAX_RANGE, 26'd1048575));
		add_row(smp_row(24'h123456, 0, none));
		add_row(smp_row(24'hfedcba, 0, none));
		add_row(smp_row(24'd0, 0, none));
		add_row(cfg_row(REG_MAX_RANGE, 26'd0));
		add_row(cfg_row(REG_RADAR_ALT, 26'd0));
		add_row(cfg_row(REG_BEAM_ELEV, 26'd0));
		add_row(smp_row(24'd256, 1, r1));
		add_row(smp_row(24'hffff00, 0, none));
		// end of radial after three steps, then restart
		add_row(cfg_row(REG_RANGE_STEP, 26'd500));
		add_row(cfg_row(REG_MAX_RANGE, 26'd1500));
		add_row(smp_row(24'd1000, 0, none));
		add_row(smp_row(24'd500, 0, none));
		add_row(smp_row(24'd9000, 0, none));
		add_row(smp_row(24'd9000, 0, none));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_sample(plan[i].val[23:0], plan[i].typed, plan[i].res);
			end
		end

		// phases: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 13 : 0;
			stall_pct = (ph == 2) ? 73 : (ph == 3) ? 13 : 0;
			rand_config();
			// long receiver hold-off while samples keep coming: fills the output
			if (ph == 0)
				hold_left = 600;
			for (int n = 0; n < PHASE_SMPS; n++) begin
				if (n != 0 && n % CFG_EVERY == 0) begin
					drain();
					rand_config();
				end
				send_sample(rand_terrain(), 0, none);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
